/* rtl/core/ppi_pkg.sv */
// ppi_pkg: command codes and fixed port widths for the polygon overlap core
// no dependencies
package ppi_pkg;

  // width of the vertex coordinate ports
  localparam int XY_W = 32;

  typedef logic [1:0] cmd_t;

  localparam cmd_t CMD_CLEAR    = 2'd0;
  localparam cmd_t CMD_APPEND_A = 2'd1;
  localparam cmd_t CMD_APPEND_B = 2'd2;
  localparam cmd_t CMD_TEST     = 2'd3;

endpackage

/* rtl/core/polygon_polygon_intersect_core.sv */
// polygon_polygon_intersect_core: vertex stores, sequencer, shared multiplier
// depends on ppi_pkg and ppi_div
//
// Usage: a command word is taken when start is high and busy is low.
// Clear and append words give no result; busy stays low.
// Appends beyond MAX_VERTICES per polygon are dropped and remembered until
// the next clear. A test word raises busy and, when finished, pulses done
// for one cycle with collide and vertex_dropped; the receiver cannot stall,
// so the result must be taken in that cycle.
// Resources of a test: one multiplier (registered operands and product) and
// one bit-serial divider of QW = 2*COORD_BITS+3+FRAC_BITS quotient bits are
// shared. Each edge pair is fetched, put through six products and up to two
// divisions; each point is held against the bounding box of the other polygon,
// then each edge, with one product and one division when the edge straddles
// the point. A test with an empty polygon answers in the cycle after the word.
// Items are handled one at a time. Reset clears counts and the drop flag;
// stores are undefined until written.
module polygon_polygon_intersect_core #(
  parameter int MAX_VERTICES = 8,
  parameter int FRAC_BITS    = 16,
  parameter int COORD_BITS   = 32
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  ppi_pkg::cmd_t                   command,
  input  logic signed [ppi_pkg::XY_W-1:0] vertex_x,
  input  logic signed [ppi_pkg::XY_W-1:0] vertex_y,
  output logic                            done,
  output logic                            collide,
  output logic                            vertex_dropped
);

  import ppi_pkg::*;

  localparam int C     = COORD_BITS;
  localparam int D     = C + 1;
  localparam int W     = 2 * D + 1;
  localparam int QW    = W + FRAC_BITS;
  localparam int CNT_W = $clog2(MAX_VERTICES + 1);
  localparam int IW    = $clog2(MAX_VERTICES);

  typedef enum logic [4:0] {
    ST_IDLE, ST_SEG_R1, ST_SEG_R2, ST_SEG_R3, ST_SEG_MUL, ST_SEG_CHK,
    ST_SEG_DIVA, ST_SEG_DIVB, ST_SEG_NEXT, ST_PT_RD, ST_BB_INIT, ST_BB,
    ST_BB_ACC, ST_BB_CHK, ST_E_RI, ST_E_RJ, ST_E_CAP, ST_E_MUL, ST_E_DGO,
    ST_E_DIV, ST_E_NEXT, ST_PT_NEXT
  } state_t;

  state_t state;

  // vertex stores, x in the upper half
  logic [2*C-1:0] mem_a [MAX_VERTICES];
  logic [2*C-1:0] mem_b [MAX_VERTICES];
  logic [2*C-1:0] da, db;
  logic [IW-1:0]  ra, rb;

  logic [CNT_W-1:0] na, nb;
  logic             ovf;

  // sequencer indexes
  logic [CNT_W-1:0] i, k, pidx, vidx, eidx, jidx;
  logic             pass;
  logic [2:0]       mstep;

  // segment endpoints
  logic signed [C-1:0] a1x, a1y, a2x, a2y, b1x, b1y, b2x, b2y;
  logic signed [W-1:0] uat, ubt, den;

  // point test registers
  logic signed [C-1:0] px, py, minx, maxx, miny, maxy, vix, viy;
  logic signed [D-1:0] dy;
  logic                odd_cross;

  // shared multiplier
  logic signed [D-1:0]   opa, opb;
  logic signed [2*D-1:0] prod;
  logic signed [W-1:0]   psh;

  // shared divider
  logic                div_go, div_done;
  logic signed [W-1:0] div_num, div_den;
  logic signed [QW:0]  quo;

  ppi_div #(.W(W), .F(FRAC_BITS)) u_div (
    .clk  (clk),
    .rst  (rst),
    .go   (div_go),
    .num  (div_num),
    .den  (div_den),
    .done (div_done),
    .quo  (quo)
  );

  // wrap-around successors and polygon roles
  logic [CNT_W-1:0] i_nx, k_nx, npoly, npts, poly_addr, pt_addr;
  logic [2*C-1:0]   poly_d, pt_d;
  logic signed [C-1:0] pdx_x, pdx_y, pt_x, pt_y, vjx, vjy;

  assign i_nx  = (i + 1'b1 == na) ? '0 : i + 1'b1;
  assign k_nx  = (k + 1'b1 == nb) ? '0 : k + 1'b1;
  assign npoly = pass ? nb : na;
  assign npts  = pass ? na : nb;
  assign poly_d = pass ? db : da;
  assign pt_d   = pass ? da : db;
  assign pdx_x = poly_d[2*C-1:C];
  assign pdx_y = poly_d[C-1:0];
  assign pt_x  = pt_d[2*C-1:C];
  assign pt_y  = pt_d[C-1:0];
  assign vjx   = pdx_x;
  assign vjy   = pdx_y;

  // read addresses per state
  always_comb begin
    poly_addr = '0;
    pt_addr   = pidx;
    unique case (state)
      ST_BB:   poly_addr = vidx;
      ST_E_RI: poly_addr = eidx;
      ST_E_RJ: poly_addr = jidx;
      default: poly_addr = '0;
    endcase
    unique case (state)
      ST_SEG_R1: begin
        ra = i[IW-1:0];
        rb = k[IW-1:0];
      end
      ST_SEG_R2: begin
        ra = i_nx[IW-1:0];
        rb = k_nx[IW-1:0];
      end
      default: begin
        ra = pass ? pt_addr[IW-1:0] : poly_addr[IW-1:0];
        rb = pass ? poly_addr[IW-1:0] : pt_addr[IW-1:0];
      end
    endcase
  end

  // store write and registered read
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && start && command == CMD_APPEND_A &&
        na != CNT_W'(MAX_VERTICES)) begin
      mem_a[na[IW-1:0]] <= {vertex_x[C-1:0], vertex_y[C-1:0]};
    end
    if (state == ST_IDLE && start && command == CMD_APPEND_B &&
        nb != CNT_W'(MAX_VERTICES)) begin
      mem_b[nb[IW-1:0]] <= {vertex_x[C-1:0], vertex_y[C-1:0]};
    end
    da <= mem_a[ra];
    db <= mem_b[rb];
  end

  // segment differences
  logic signed [D-1:0] dbx, dby, dax, day, ox, oy;
  assign dbx = D'(b2x) - D'(b1x);
  assign dby = D'(b2y) - D'(b1y);
  assign dax = D'(a2x) - D'(a1x);
  assign day = D'(a2y) - D'(a1y);
  assign ox  = D'(a1x) - D'(b1x);
  assign oy  = D'(a1y) - D'(b1y);

  // multiplier: product always registered from operand registers
  always_ff @(posedge clk) begin
    prod <= opa * opb;
  end
  assign psh = W'(prod >>> FRAC_BITS);

  // quotient range checks
  localparam logic signed [QW:0] ONE = (QW+1)'(1) << FRAC_BITS;
  logic q_in_unit, q_gt_dx;
  logic signed [D-1:0] pxd;
  assign q_in_unit = !quo[QW] && (quo <= ONE);
  assign pxd       = D'(px) - D'(vix);
  assign q_gt_dx   = $signed((QW+1)'(pxd)) < quo;

  assign busy = (state != ST_IDLE);

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      na             <= '0;
      nb             <= '0;
      ovf            <= 1'b0;
      done           <= 1'b0;
      div_go         <= 1'b0;
      collide        <= 1'b0;
      vertex_dropped <= 1'b0;
    end else begin
      done   <= 1'b0;
      div_go <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            unique case (command)
              CMD_CLEAR: begin
                na  <= '0;
                nb  <= '0;
                ovf <= 1'b0;
              end
              CMD_APPEND_A: begin
                if (na == CNT_W'(MAX_VERTICES)) ovf <= 1'b1;
                else na <= na + 1'b1;
              end
              CMD_APPEND_B: begin
                if (nb == CNT_W'(MAX_VERTICES)) ovf <= 1'b1;
                else nb <= nb + 1'b1;
              end
              CMD_TEST: begin
                if (na == '0 || nb == '0) begin
                  done           <= 1'b1;
                  collide        <= 1'b0;
                  vertex_dropped <= ovf;
                end else begin
                  i     <= '0;
                  k     <= '0;
                  state <= ST_SEG_R1;
                end
              end
              default: ;
            endcase
          end
        end
        // edge pair fetch
        ST_SEG_R1: state <= ST_SEG_R2;
        ST_SEG_R2: begin
          a1x   <= da[2*C-1:C];
          a1y   <= da[C-1:0];
          b1x   <= db[2*C-1:C];
          b1y   <= db[C-1:0];
          state <= ST_SEG_R3;
        end
        ST_SEG_R3: begin
          a2x   <= da[2*C-1:C];
          a2y   <= da[C-1:0];
          b2x   <= db[2*C-1:C];
          b2y   <= db[C-1:0];
          mstep <= '0;
          state <= ST_SEG_MUL;
        end
        // six products streamed through the multiplier
        ST_SEG_MUL: begin
          case (mstep)
            3'd0: begin opa <= dbx; opb <= oy;  end
            3'd1: begin opa <= dby; opb <= ox;  end
            3'd2: begin opa <= dax; opb <= oy;  end
            3'd3: begin opa <= day; opb <= ox;  end
            3'd4: begin opa <= dby; opb <= dax; end
            3'd5: begin opa <= dbx; opb <= day; end
            default: ;
          endcase
          case (mstep)
            3'd2: uat <= psh;
            3'd3: uat <= uat - psh;
            3'd4: ubt <= psh;
            3'd5: ubt <= ubt - psh;
            3'd6: den <= psh;
            3'd7: den <= den - psh;
            default: ;
          endcase
          mstep <= mstep + 1'b1;
          if (mstep == 3'd7) state <= ST_SEG_CHK;
        end
        ST_SEG_CHK: begin
          if (den == '0) begin
            state <= ST_SEG_NEXT;
          end else begin
            div_num <= uat;
            div_den <= den;
            div_go  <= 1'b1;
            state   <= ST_SEG_DIVA;
          end
        end
        ST_SEG_DIVA: begin
          if (div_done) begin
            if (q_in_unit) begin
              div_num <= ubt;
              div_go  <= 1'b1;
              state   <= ST_SEG_DIVB;
            end else begin
              state <= ST_SEG_NEXT;
            end
          end
        end
        ST_SEG_DIVB: begin
          if (div_done) begin
            if (q_in_unit) begin
              done           <= 1'b1;
              collide        <= 1'b1;
              vertex_dropped <= ovf;
              state          <= ST_IDLE;
            end else begin
              state <= ST_SEG_NEXT;
            end
          end
        end
        ST_SEG_NEXT: begin
          if (k + 1'b1 != nb) begin
            k     <= k + 1'b1;
            state <= ST_SEG_R1;
          end else if (i + 1'b1 != na) begin
            k     <= '0;
            i     <= i + 1'b1;
            state <= ST_SEG_R1;
          end else begin
            pass  <= 1'b0;
            pidx  <= '0;
            state <= ST_PT_RD;
          end
        end
        // point fetch and bounding box
        ST_PT_RD: state <= ST_BB_INIT;
        ST_BB_INIT: begin
          px   <= pt_x;
          py   <= pt_y;
          minx <= pdx_x;
          maxx <= pdx_x;
          miny <= pdx_y;
          maxy <= pdx_y;
          vidx <= CNT_W'(1);
          state <= (npoly == CNT_W'(1)) ? ST_BB_CHK : ST_BB;
        end
        ST_BB: state <= ST_BB_ACC;
        ST_BB_ACC: begin
          if (pdx_x < minx) minx <= pdx_x;
          if (pdx_x > maxx) maxx <= pdx_x;
          if (pdx_y < miny) miny <= pdx_y;
          if (pdx_y > maxy) maxy <= pdx_y;
          vidx <= vidx + 1'b1;
          state <= (vidx + 1'b1 == npoly) ? ST_BB_CHK : ST_BB;
        end
        ST_BB_CHK: begin
          if (px < minx || px > maxx || py < miny || py > maxy) begin
            state <= ST_PT_NEXT;
          end else begin
            eidx      <= '0;
            jidx      <= npoly - 1'b1;
            odd_cross <= 1'b0;
            state     <= ST_E_RI;
          end
        end
        // crossing-number walk over the edges
        ST_E_RI: state <= ST_E_RJ;
        ST_E_RJ: begin
          vix   <= pdx_x;
          viy   <= pdx_y;
          state <= ST_E_CAP;
        end
        ST_E_CAP: begin
          opa <= D'(vjx) - D'(vix);
          opb <= D'(py) - D'(viy);
          dy  <= D'(vjy) - D'(viy);
          state <= ((viy > py) != (vjy > py)) ? ST_E_MUL : ST_E_NEXT;
        end
        ST_E_MUL: state <= ST_E_DGO;
        ST_E_DGO: begin
          div_num <= psh;
          div_den <= W'(dy);
          div_go  <= 1'b1;
          state   <= ST_E_DIV;
        end
        ST_E_DIV: begin
          if (div_done) begin
            if (q_gt_dx) odd_cross <= !odd_cross;
            state <= ST_E_NEXT;
          end
        end
        ST_E_NEXT: begin
          if (eidx + 1'b1 == npoly) begin
            if (odd_cross) begin
              done           <= 1'b1;
              collide        <= 1'b1;
              vertex_dropped <= ovf;
              state          <= ST_IDLE;
            end else begin
              state <= ST_PT_NEXT;
            end
          end else begin
            jidx  <= eidx;
            eidx  <= eidx + 1'b1;
            state <= ST_E_RI;
          end
        end
        ST_PT_NEXT: begin
          if (pidx + 1'b1 != npts) begin
            pidx  <= pidx + 1'b1;
            state <= ST_PT_RD;
          end else if (!pass) begin
            pass  <= 1'b1;
            pidx  <= '0;
            state <= ST_PT_RD;
          end else begin
            done           <= 1'b1;
            collide        <= 1'b0;
            vertex_dropped <= ovf;
            state          <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

/* rtl/core/ppi_div.sv */
// ppi_div: iterative signed fixed-point divider, one quotient bit per cycle
// computes (num << F) / den truncated toward zero; no package dependency
module ppi_div #(
  parameter int W = 67,
  parameter int F = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                go,
  input  logic signed [W-1:0] num,
  input  logic signed [W-1:0] den,
  output logic                done,
  output logic signed [W+F:0] quo
);

  localparam int QW = W + F;
  localparam int CW = $clog2(QW + 1);

  logic          running;
  logic [CW-1:0] cnt;
  logic [W:0]    rem;
  logic [QW-1:0] dvd;
  logic [W-1:0]  dsr;
  logic [QW-1:0] qmag;
  logic          neg;

  logic [W-1:0]  abs_num;
  logic [W-1:0]  abs_den;
  logic [W:0]    trial;
  logic          qbit;

  // magnitudes of the operands
  assign abs_num = num[W-1] ? W'(-num) : W'(num);
  assign abs_den = den[W-1] ? W'(-den) : W'(den);

  // restoring step
  assign trial = {rem[W-1:0], dvd[QW-1]};
  assign qbit  = (trial >= {1'b0, dsr});

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        running <= 1'b1;
        cnt     <= CW'(QW);
        rem     <= '0;
        dvd     <= QW'(abs_num) << F;
        dsr     <= abs_den;
        qmag    <= '0;
        neg     <= num[W-1] ^ den[W-1];
      end else if (running) begin
        rem  <= qbit ? (trial - {1'b0, dsr}) : trial;
        dvd  <= dvd << 1;
        qmag <= {qmag[QW-2:0], qbit};
        cnt  <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  // signed quotient
  assign quo = neg ? -$signed({1'b0, qmag}) : $signed({1'b0, qmag});

endmodule

/* bench/polygon_polygon_intersect_core_test.sv */
// polygon_polygon_intersect_core_test: self-checking bench for the polygon overlap core
// depends on ppi_pkg and polygon_polygon_intersect_core
module polygon_polygon_intersect_core_test;
  import ppi_pkg::*;

  localparam int MAXV = 8;
  localparam int FRAC = 16;

  typedef logic signed [127:0] wide_t;

  typedef struct {
    cmd_t        cmd;
    logic [31:0] x;
    logic [31:0] y;
  } word_t;

  typedef struct {
    logic collide;
    logic dropped;
  } verdict_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  cmd_t        command = CMD_CLEAR;
  logic signed [XY_W-1:0] vertex_x = '0;
  logic signed [XY_W-1:0] vertex_y = '0;
  logic        busy, done, collide, vertex_dropped;

  word_t    pending_words[$];
  verdict_t verdicts_due[$];
  word_t    cur_word;
  int       idle_left = 0;
  bit       failed = 0;

  // shadow copy of the polygon stores
  longint   shadow_ax[MAXV], shadow_ay[MAXV], shadow_bx[MAXV], shadow_by[MAXV];
  int       shadow_na = 0, shadow_nb = 0;
  bit       shadow_drop = 0;

  polygon_polygon_intersect_core #(
    .MAX_VERTICES(MAXV),
    .FRAC_BITS(FRAC),
    .COORD_BITS(32)
  ) dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .command(command),
    .vertex_x(vertex_x),
    .vertex_y(vertex_y),
    .done(done),
    .collide(collide),
    .vertex_dropped(vertex_dropped)
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // product of two differences, floored by the fraction bits
  function automatic wide_t fx_mul(longint a, longint b);
    wide_t p;
    p = wide_t'(a) * wide_t'(b);
    return p >>> FRAC;
  endfunction

  // quotient truncated toward zero
  function automatic wide_t fx_div(wide_t n, wide_t d);
    return (n <<< FRAC) / d;
  endfunction

  function automatic bit edges_cross(longint a1x, longint a1y, longint a2x, longint a2y,
                                     longint b1x, longint b1y, longint b2x, longint b2y);
    longint dbx, dby, dax, day, ox, oy;
    wide_t  uat, ubt, den, ua, ub, one;
    dbx = b2x - b1x;
    dby = b2y - b1y;
    dax = a2x - a1x;
    day = a2y - a1y;
    ox = a1x - b1x;
    oy = a1y - b1y;
    uat = fx_mul(dbx, oy) - fx_mul(dby, ox);
    ubt = fx_mul(dax, oy) - fx_mul(day, ox);
    den = fx_mul(dby, dax) - fx_mul(dbx, day);
    one = wide_t'(64'sd1 <<< FRAC);
    if (den == 0) return 0;
    ua = fx_div(uat, den);
    ub = fx_div(ubt, den);
    return ua >= 0 && ua <= one && ub >= 0 && ub <= one;
  endfunction

  // crossing parity of point p against polygon A (in_a) or B
  function automatic bit point_enclosed(bit in_a, longint px, longint py);
    longint vx[MAXV], vy[MAXV];
    longint minx, maxx, miny, maxy;
    int     n, j;
    bit     odd;
    wide_t  m, q;
    n = in_a ? shadow_na : shadow_nb;
    for (int i = 0; i < n; i++) begin
      vx[i] = in_a ? shadow_ax[i] : shadow_bx[i];
      vy[i] = in_a ? shadow_ay[i] : shadow_by[i];
    end
    minx = vx[0]; maxx = vx[0]; miny = vy[0]; maxy = vy[0];
    for (int i = 1; i < n; i++) begin
      if (vx[i] < minx) minx = vx[i];
      if (vx[i] > maxx) maxx = vx[i];
      if (vy[i] < miny) miny = vy[i];
      if (vy[i] > maxy) maxy = vy[i];
    end
    if (px < minx || px > maxx || py < miny || py > maxy) return 0;
    odd = 0;
    j = n - 1;
    for (int i = 0; i < n; i++) begin
      if ((vy[i] > py) != (vy[j] > py)) begin
        m = fx_mul(vx[j] - vx[i], py - vy[i]);
        q = fx_div(m, wide_t'(vy[j] - vy[i]));
        if (wide_t'(px - vx[i]) < q) odd = !odd;
      end
      j = i;
    end
    return odd;
  endfunction

  function automatic bit polygons_overlap();
    int inx, knx;
    if (shadow_na == 0 || shadow_nb == 0) return 0;
    for (int i = 0; i < shadow_na; i++) begin
      inx = (i + 1 == shadow_na) ? 0 : i + 1;
      for (int k = 0; k < shadow_nb; k++) begin
        knx = (k + 1 == shadow_nb) ? 0 : k + 1;
        if (edges_cross(shadow_ax[i], shadow_ay[i], shadow_ax[inx], shadow_ay[inx],
                        shadow_bx[k], shadow_by[k], shadow_bx[knx], shadow_by[knx]))
          return 1;
      end
    end
    for (int k = 0; k < shadow_nb; k++)
      if (point_enclosed(1, shadow_bx[k], shadow_by[k])) return 1;
    for (int i = 0; i < shadow_na; i++)
      if (point_enclosed(0, shadow_ax[i], shadow_ay[i])) return 1;
    return 0;
  endfunction

  // update the shadow stores for one accepted word
  task automatic apply_word(word_t w);
    verdict_t v;
    case (w.cmd)
      CMD_CLEAR: begin
        shadow_na = 0;
        shadow_nb = 0;
        shadow_drop = 0;
      end
      CMD_APPEND_A: begin
        if (shadow_na < MAXV) begin
          shadow_ax[shadow_na] = longint'($signed(w.x));
          shadow_ay[shadow_na] = longint'($signed(w.y));
          shadow_na++;
        end else shadow_drop = 1;
      end
      CMD_APPEND_B: begin
        if (shadow_nb < MAXV) begin
          shadow_bx[shadow_nb] = longint'($signed(w.x));
          shadow_by[shadow_nb] = longint'($signed(w.y));
          shadow_nb++;
        end else shadow_drop = 1;
      end
      default: begin
        v.collide = polygons_overlap();
        v.dropped = shadow_drop;
        verdicts_due.push_back(v);
      end
    endcase
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // driver: one word at a time, random gaps between words
  always @(posedge clk) begin
    bit start_n;
    if (rst) begin
      start <= 1'b0;
    end else begin
      start_n = start;
      if (start && !busy) begin
        apply_word(cur_word);
        start_n = 0;
      end
      if (!start_n) begin
        if (idle_left > 0) idle_left--;
        else if (pending_words.size() > 0) begin
          cur_word = pending_words.pop_front();
          command <= cur_word.cmd;
          vertex_x <= cur_word.x;
          vertex_y <= cur_word.y;
          start_n = 1;
          idle_left = pick_gap();
        end
      end
      start <= start_n;
    end
  end

  // monitor: compare each test result with the oldest prediction
  always @(posedge clk) begin
    verdict_t v;
    if (!rst && done) begin
      if (verdicts_due.size() == 0) begin
        $error("result with no prediction waiting");
        failed = 1;
      end else begin
        v = verdicts_due.pop_front();
        if (collide !== v.collide) begin
          $error("collide expected %0b actual %0b", v.collide, collide);
          failed = 1;
        end
        if (vertex_dropped !== v.dropped) begin
          $error("vertex_dropped expected %0b actual %0b", v.dropped, vertex_dropped);
          failed = 1;
        end
      end
    end
  end

  task automatic push_word(cmd_t c, longint x, longint y);
    word_t w;
    w.cmd = c;
    w.x = x[31:0];
    w.y = y[31:0];
    pending_words.push_back(w);
  endtask

  // mostly near the origin so shapes meet; sometimes anywhere in range
  function automatic longint rand_coord();
    if ($urandom_range(0, 9) == 0) return longint'($signed($urandom()));
    return longint'($urandom_range(0, 16 << 16)) - (8 << 16);
  endfunction

  function automatic int rand_count();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return 0;
    if (r == 1) return $urandom_range(9, 10);
    if (r < 4) return $urandom_range(1, 2);
    if (r < 17) return $urandom_range(3, 4);
    return $urandom_range(5, 8);
  endfunction

  // stimulus and end of run
  initial begin
    longint big, tiny;
    int     na, nb;
    big = 64'sd2147483647;
    tiny = -64'sd2147483648;
    // test with both polygons empty, then with only A loaded
    push_word(CMD_TEST, 0, 0);
    push_word(CMD_APPEND_A, 0, 0);
    push_word(CMD_TEST, big, tiny);
    // one vertex each, same point
    push_word(CMD_APPEND_B, 0, 0);
    push_word(CMD_TEST, 0, 0);
    // extreme coordinates: huge triangle around a small one
    push_word(CMD_CLEAR, big, big);
    push_word(CMD_APPEND_A, tiny, tiny);
    push_word(CMD_APPEND_A, big, tiny);
    push_word(CMD_APPEND_A, 0, big);
    push_word(CMD_APPEND_B, 1 << 16, 1 << 16);
    push_word(CMD_APPEND_B, 2 << 16, 1 << 16);
    push_word(CMD_APPEND_B, 1 << 16, 2 << 16);
    push_word(CMD_TEST, 0, 0);
    // overfill A so the drop flag sets
    for (int i = 0; i < 6; i++) push_word(CMD_APPEND_A, i << 16, -i << 16);
    push_word(CMD_TEST, 0, 0);
    // clear resets the drop flag
    push_word(CMD_CLEAR, 0, 0);
    push_word(CMD_TEST, 0, 0);
    // two-vertex polygons touching at one corner
    push_word(CMD_APPEND_A, 0, 0);
    push_word(CMD_APPEND_A, 1 << 16, 1 << 16);
    push_word(CMD_APPEND_B, 1 << 16, 1 << 16);
    push_word(CMD_APPEND_B, 3 << 16, 3 << 16);
    push_word(CMD_TEST, 0, 0);

    // random polygon pairs, with some loose words mixed in
    while (pending_words.size() < 1750) begin
      if ($urandom_range(0, 9) == 0) begin
        push_word(cmd_t'($urandom_range(0, 3)), rand_coord(), rand_coord());
      end else begin
        na = rand_count();
        nb = rand_count();
        push_word(CMD_CLEAR, rand_coord(), rand_coord());
        for (int i = 0; i < na; i++) push_word(CMD_APPEND_A, rand_coord(), rand_coord());
        for (int i = 0; i < nb; i++) push_word(CMD_APPEND_B, rand_coord(), rand_coord());
        push_word(CMD_TEST, rand_coord(), rand_coord());
        if ($urandom_range(0, 3) == 0) push_word(CMD_TEST, rand_coord(), rand_coord());
      end
    end

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    wait (pending_words.size() == 0);
    @(posedge clk);
    while (start || verdicts_due.size() > 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (!failed) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

  // watchdog
  initial begin
    #2000000000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

/* polygon_polygon_intersect_core.f */
rtl/core/ppi_pkg.sv
rtl/core/ppi_div.sv
rtl/core/polygon_polygon_intersect_core.sv
bench/polygon_polygon_intersect_core_test.sv
